/* sv/priority_affinity_thread_scheduler_top_assert.svh */
// assertion macros for the thread scheduler top level
// no dependencies; included by the top level only
`ifndef PRIORITY_AFFINITY_THREAD_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_AFFINITY_THREAD_SCHEDULER_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PATS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PATS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/pats_pkg.sv */
// shared types and constants of the thread scheduler
// no dependencies
package pats_pkg;

   localparam int unsigned MaxThreads  = 32;
   localparam int unsigned MaxPriority = 31;
   localparam int unsigned NumCpus     = 16;

   localparam int unsigned IdW   = 6;
   localparam int unsigned IdxW  = 5;
   localparam int unsigned PrioW = 5;
   localparam int unsigned AffW  = 16;
   localparam int unsigned CntW  = 6;
   localparam int unsigned QDepth = 2;

   typedef enum logic [3:0] {
      OP_CREATE    = 4'd0,
      OP_START     = 4'd1,
      OP_YIELD     = 4'd2,
      OP_TERMINATE = 4'd3,
      OP_SET_PRIO  = 4'd4,
      OP_GET_PRIO  = 4'd5,
      OP_SET_AFF   = 4'd6,
      OP_GET_AFF   = 4'd7,
      OP_SCHEDULE  = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      ST_UNUSED     = 3'd0,
      ST_INIT       = 3'd1,
      ST_READY      = 3'd2,
      ST_RUNNING    = 3'd3,
      ST_TERMINATED = 3'd4
   } status_type;

   // classified command handed from front to back
   typedef struct packed {
      logic              valid_op;
      op_type            op;
      logic              id_ok;
      logic [IdxW-1:0]   idx;
      logic [PrioW-1:0]  prio;
      logic              cpu_ok;
      logic [3:0]        cpu;
      logic [AffW-1:0]   mask;
   } cmd_type;

   function automatic logic [PrioW-1:0] clamp_prio(input logic [7:0] p);
      logic [PrioW-1:0] r;
      if (p > 8'(MaxPriority)) r = PrioW'(MaxPriority);
      else                     r = p[PrioW-1:0];
      return r;
   endfunction

endpackage

/* sv/pats_front.sv */
// front end: takes commands, range-checks ids and cpu, clamps priority
// depends on pats_pkg
module pats_front (
   input  logic                  start,
   input  logic                  busy,
   input  logic [3:0]            req_op,
   input  logic [5:0]            req_thread_id,
   input  logic [7:0]            req_priority_req,
   input  logic [3:0]            req_cpu,
   input  logic [15:0]           req_affinity_mask,
   output logic                  push,
   output pats_pkg::cmd_type     cmd
);
   logic [pats_pkg::IdW-1:0] idm1;

   always_comb begin
      idm1 = req_thread_id - pats_pkg::IdW'(1);
      push = start && !busy;
      cmd.valid_op = (req_op <= 4'(pats_pkg::OP_SCHEDULE));
      cmd.op       = pats_pkg::op_type'(req_op);
      cmd.id_ok    = (req_thread_id != '0) &&
                     (req_thread_id <= pats_pkg::IdW'(pats_pkg::MaxThreads));
      cmd.idx      = idm1[pats_pkg::IdxW-1:0];
      cmd.prio     = pats_pkg::clamp_prio(req_priority_req);
      cmd.cpu_ok   = (32'(req_cpu) < pats_pkg::NumCpus);
      cmd.cpu      = req_cpu;
      cmd.mask     = req_affinity_mask;
   end
endmodule

/* sv/pats_queue.sv */
// short command queue between front and back
// depends on pats_pkg
module pats_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pats_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              not_empty,
   output logic              full,
   output pats_pkg::cmd_type head
);
   pats_pkg::cmd_type slot_ff [pats_pkg::QDepth];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      not_empty = (cnt_ff != 2'd0);
      full      = (cnt_ff == 2'(pats_pkg::QDepth));
      head      = slot_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= push_cmd;
   end
endmodule

/* sv/pats_back.sv */
// back end: thread table, command execution and the sequential schedule scan
// depends on pats_pkg
module pats_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      have_cmd,
   input  pats_pkg::cmd_type         cmd,
   input  logic [15:0]               dflt_aff,
   output logic                      pop,
   output logic                      idle,
   output logic                      rsp_valid,
   output logic                      rsp_ok,
   output logic [5:0]                rsp_thread_id_out,
   output logic [4:0]                rsp_prio_level,
   output logic [15:0]               rsp_affinity_out,
   output logic [5:0]                rsp_ready_count,
   output logic [5:0]                rsp_active_count
);
   localparam int unsigned N = pats_pkg::MaxThreads;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   pats_pkg::status_type status_ff [N];
   logic [pats_pkg::PrioW-1:0] prio_mem [N];
   logic [pats_pkg::AffW-1:0]  aff_mem  [N];
   logic [31:0]                stamp_mem[N];
   logic [pats_pkg::IdW-1:0]   next_id_ff;
   logic [31:0]                stamp_ctr_ff;

   logic [pats_pkg::IdxW:0]    scan_ff, scan_in;
   logic                       best_v_ff, best_v_in;
   logic [pats_pkg::IdxW-1:0]  best_ff, best_in;
   logic [pats_pkg::PrioW-1:0] bprio_ff, bprio_in;
   logic [31:0]                bage_ff, bage_in;
   pats_pkg::cmd_type          cur_ff;
   logic [pats_pkg::CntW-1:0]  rdy_ff, act_ff;

   logic                       out_v_ff, out_v_in, out_ok_ff, out_ok_in;
   logic [5:0]                 out_id_ff, out_id_in;
   logic [4:0]                 out_pr_ff, out_pr_in;
   logic [15:0]                out_af_ff, out_af_in;

   logic [pats_pkg::IdxW-1:0]  si;
   logic [31:0]                age;
   logic                       cand;
   logic                       known;
   pats_pkg::status_type       cst;
   logic                       doit;

   always_comb begin
      si   = scan_ff[pats_pkg::IdxW-1:0];
      age  = stamp_ctr_ff - stamp_mem[si];
      cand = (status_ff[si] == pats_pkg::ST_READY) && aff_mem[si][cur_ff.cpu];
      cst  = status_ff[cmd.idx];
      known = cmd.id_ok && (cst != pats_pkg::ST_UNUSED);
      doit  = (state_ff == S_IDLE) && have_cmd;
      pop   = doit;
      idle  = (state_ff == S_IDLE) && !have_cmd && !out_v_ff;
      out_v_in = (doit && !(cmd.valid_op && cmd.op == pats_pkg::OP_SCHEDULE && cmd.cpu_ok)) ||
                 (state_ff == S_DONE);
      state_in = state_ff;
      scan_in = scan_ff; best_v_in = best_v_ff; best_in = best_ff;
      bprio_in = bprio_ff; bage_in = bage_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (doit && cmd.valid_op && cmd.op == pats_pkg::OP_SCHEDULE && cmd.cpu_ok) begin
               state_in = S_SCAN; scan_in = '0; best_v_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (cand && (!best_v_ff || prio_mem[si] < bprio_ff ||
                (prio_mem[si] == bprio_ff && age > bage_ff))) begin
               best_v_in = 1'b1; best_in = si; bprio_in = prio_mem[si]; bage_in = age;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == (pats_pkg::IdxW+1)'(N-1)) state_in = S_DONE;
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // result fields, loaded whenever a result is issued
   always_comb begin
      out_ok_in = 1'b0; out_id_in = '0; out_pr_in = '0; out_af_in = '0;
      if (state_ff == S_DONE) begin
         out_ok_in = best_v_ff;
         out_id_in = best_v_ff ? (pats_pkg::IdW'(best_ff) + 1'b1) : '0;
      end else if (doit && cmd.valid_op) begin
         unique case (cmd.op)
            pats_pkg::OP_CREATE:
               if (32'(next_id_ff) <= N) begin
                  out_ok_in = 1'b1; out_id_in = next_id_ff;
               end
            pats_pkg::OP_START, pats_pkg::OP_YIELD, pats_pkg::OP_TERMINATE,
            pats_pkg::OP_SET_PRIO, pats_pkg::OP_SET_AFF:
               out_ok_in = known;
            pats_pkg::OP_GET_PRIO: if (known) begin
               out_pr_in = prio_mem[cmd.idx]; out_ok_in = 1'b1;
            end
            pats_pkg::OP_GET_AFF: if (known) begin
               out_af_in = aff_mem[cmd.idx]; out_ok_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // counts are kept incrementally from every status write
   function automatic logic is_rdy(input pats_pkg::status_type s);
      return s == pats_pkg::ST_READY;
   endfunction
   function automatic logic is_act(input pats_pkg::status_type s);
      return s == pats_pkg::ST_READY || s == pats_pkg::ST_RUNNING;
   endfunction

   pats_pkg::status_type old_s, new_s;
   logic                 wr_s;
   logic [pats_pkg::IdxW-1:0] wr_i;
   logic [pats_pkg::CntW-1:0] rdy_n, act_n;

   always_comb begin
      wr_s = 1'b0; wr_i = cmd.idx; new_s = cst;
      if (doit && cmd.valid_op) begin
         unique case (cmd.op)
            pats_pkg::OP_CREATE: begin
               wr_i = next_id_ff[pats_pkg::IdxW-1:0] - pats_pkg::IdxW'(1);
               wr_s = (32'(next_id_ff) <= N); new_s = pats_pkg::ST_INIT;
            end
            pats_pkg::OP_START: begin wr_s = known; new_s = pats_pkg::ST_READY; end
            pats_pkg::OP_YIELD: begin
               wr_s = known && cst == pats_pkg::ST_RUNNING; new_s = pats_pkg::ST_READY;
            end
            pats_pkg::OP_TERMINATE: begin wr_s = known; new_s = pats_pkg::ST_TERMINATED; end
            default: ;
         endcase
      end else if (state_ff == S_DONE && best_v_ff) begin
         wr_s = 1'b1; wr_i = best_ff; new_s = pats_pkg::ST_RUNNING;
      end
      old_s = status_ff[wr_i];
      rdy_n = rdy_ff; act_n = act_ff;
      if (wr_s) begin
         rdy_n = rdy_ff - pats_pkg::CntW'(is_rdy(old_s)) + pats_pkg::CntW'(is_rdy(new_s));
         act_n = act_ff - pats_pkg::CntW'(is_act(old_s)) + pats_pkg::CntW'(is_act(new_s));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < N; i++) status_ff[i] <= pats_pkg::ST_UNUSED;
         next_id_ff <= pats_pkg::IdW'(1);
         stamp_ctr_ff <= '0;
         rdy_ff <= '0; act_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdy_ff <= rdy_n; act_ff <= act_n;
         if (wr_s) status_ff[wr_i] <= new_s;
         out_v_ff <= out_v_in;
         if (doit && cmd.valid_op) begin
            unique case (cmd.op)
               pats_pkg::OP_CREATE:
                  if (32'(next_id_ff) <= N) next_id_ff <= next_id_ff + 1'b1;
               pats_pkg::OP_START:
                  if (known) stamp_ctr_ff <= stamp_ctr_ff + 32'd1;
               pats_pkg::OP_YIELD:
                  if (known && cst == pats_pkg::ST_RUNNING) stamp_ctr_ff <= stamp_ctr_ff + 32'd1;
               pats_pkg::OP_SET_PRIO:
                  if (known && cst == pats_pkg::ST_READY) stamp_ctr_ff <= stamp_ctr_ff + 32'd1;
               default: ;
            endcase
         end
      end
   end

   // payload: table contents, scan registers, result fields
   always_ff @(posedge clock) begin
      scan_ff <= scan_in; best_v_ff <= best_v_in; best_ff <= best_in;
      bprio_ff <= bprio_in; bage_ff <= bage_in;
      if (doit) begin
         cur_ff <= cmd;
         if (cmd.valid_op) begin
            unique case (cmd.op)
               pats_pkg::OP_CREATE:
                  if (32'(next_id_ff) <= N) begin
                     prio_mem[wr_i] <= cmd.prio; aff_mem[wr_i] <= dflt_aff;
                     stamp_mem[wr_i] <= '0;
                  end
               pats_pkg::OP_START: if (known) stamp_mem[cmd.idx] <= stamp_ctr_ff;
               pats_pkg::OP_YIELD:
                  if (known && cst == pats_pkg::ST_RUNNING) stamp_mem[cmd.idx] <= stamp_ctr_ff;
               pats_pkg::OP_SET_PRIO: if (known) begin
                  prio_mem[cmd.idx] <= cmd.prio;
                  if (cst == pats_pkg::ST_READY) stamp_mem[cmd.idx] <= stamp_ctr_ff;
               end
               pats_pkg::OP_SET_AFF: if (known) aff_mem[cmd.idx] <= cmd.mask;
               default: ;
            endcase
         end
      end
      if (out_v_in) begin
         out_ok_ff <= out_ok_in; out_id_ff <= out_id_in;
         out_pr_ff <= out_pr_in; out_af_ff <= out_af_in;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_ok            = out_ok_ff;
   assign rsp_thread_id_out = out_id_ff;
   assign rsp_prio_level    = out_pr_ff;
   assign rsp_affinity_out  = out_af_ff;
   assign rsp_ready_count   = rdy_ff;
   assign rsp_active_count  = act_ff;
endmodule

/* sv/priority_affinity_thread_scheduler_top.sv */
// top level of the thread scheduler: front, command queue, back, config register
// depends on pats_pkg, pats_front, pats_queue, pats_back and the assert header
//
//  channel   ports                       handshake
//  request   req_* , start, busy         start && !busy
//  result    rsp_*, rsp_valid            one-cycle strobe, no backpressure
//  config    csr_*                       csr_valid && csr_ready
//
// a plain command passes the command queue and the registered result stage; schedule
// scans the 32-entry table one entry a cycle. the command queue holds up to two
// commands while the back works; busy is high when the queue is full.
// synchronous active-high reset empties the table; no clearing pass is needed.
`include "priority_affinity_thread_scheduler_top_assert.svh"
module priority_affinity_thread_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_op,
   input  logic [5:0]  req_thread_id,
   input  logic [7:0]  req_priority_req,
   input  logic [3:0]  req_cpu,
   input  logic [15:0] req_affinity_mask,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [5:0]  rsp_thread_id_out,
   output logic [4:0]  rsp_prio_level,
   output logic [15:0] rsp_affinity_out,
   output logic [5:0]  rsp_ready_count,
   output logic [5:0]  rsp_active_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_default_affinity
);
   logic              push, pop, not_empty, full, idle;
   pats_pkg::cmd_type fcmd, head;
   logic [15:0]       dflt_aff_ff;

   assign busy      = full;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) dflt_aff_ff <= 16'hFFFF;
      else if (csr_valid && csr_ready) dflt_aff_ff <= csr_default_affinity;
   end

   pats_front u_front (
      .start, .busy,
      .req_op, .req_thread_id, .req_priority_req, .req_cpu, .req_affinity_mask,
      .push, .cmd(fcmd)
   );

   pats_queue u_queue (
      .clock, .reset, .push, .push_cmd(fcmd), .pop,
      .not_empty, .full, .head
   );

   pats_back u_back (
      .clock, .reset, .have_cmd(not_empty), .cmd(head), .dflt_aff(dflt_aff_ff),
      .pop, .idle,
      .rsp_valid, .rsp_ok, .rsp_thread_id_out, .rsp_prio_level, .rsp_affinity_out,
      .rsp_ready_count, .rsp_active_count
   );

   `PATS_ASSERT_IMP(a_active_ge_ready, clock, reset, 1'b1,
      rsp_active_count >= rsp_ready_count, "active count below ready count")
   `PATS_ASSERT_IMP(a_no_push_full, clock, reset, full, !push, "push into full queue")
   `PATS_ASSERT_NXT(a_idle_no_rsp, clock, reset, idle && !push, !rsp_valid,
      "result without a command")
   `PATS_ASSERT_IMP(a_ok_id, clock, reset, rsp_valid && rsp_thread_id_out != 6'd0,
      rsp_ok, "thread id reported without ok")
endmodule

/* dv/tb_priority_affinity_thread_scheduler_top.sv */
// self-checking testbench for the thread scheduler top level
// depends on pats_pkg and priority_affinity_thread_scheduler_top
// commands are predicted at transfer and results checked in order
module tb_priority_affinity_thread_scheduler_top;

   typedef struct {
      logic [3:0]  op;
      logic [5:0]  tid;
      logic [7:0]  prio;
      logic [3:0]  cpu;
      logic [15:0] mask;
   } command_type;

   typedef struct {
      logic        ok;
      logic [5:0]  tid;
      logic [4:0]  prio;
      logic [15:0] aff;
      logic [5:0]  nready;
      logic [5:0]  nactive;
   } reply_type;

   localparam int unsigned CycleLimit = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_op = '0;
   logic [5:0]  req_thread_id = '0;
   logic [7:0]  req_priority_req = '0;
   logic [3:0]  req_cpu = '0;
   logic [15:0] req_affinity_mask = '0;
   logic        rsp_valid;
   logic        rsp_ok;
   logic [5:0]  rsp_thread_id_out;
   logic [4:0]  rsp_prio_level;
   logic [15:0] rsp_affinity_out;
   logic [5:0]  rsp_ready_count;
   logic [5:0]  rsp_active_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_default_affinity = '0;

   command_type pending_cmds[$];
   reply_type   expected_replies[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          calm = 1'b0;

   // shadow of the thread table
   pats_pkg::status_type tbl_status[1:pats_pkg::MaxThreads];
   logic [4:0]  tbl_prio[1:pats_pkg::MaxThreads];
   logic [15:0] tbl_aff[1:pats_pkg::MaxThreads];
   logic [31:0] tbl_stamp[1:pats_pkg::MaxThreads];
   int unsigned next_id;
   logic [31:0] stamp_ctr;
   logic [15:0] default_aff;

   priority_affinity_thread_scheduler_top uut (.*);

   initial forever #1 clock = ~clock;

   function automatic logic [4:0] limit_prio(logic [7:0] p);
      return (p > 8'(pats_pkg::MaxPriority)) ? 5'(pats_pkg::MaxPriority) : p[4:0];
   endfunction

   task automatic mark_ready(int unsigned id);
      tbl_status[id] = pats_pkg::ST_READY;
      tbl_stamp[id]  = stamp_ctr;
      stamp_ctr      = stamp_ctr + 1;
   endtask

   task automatic run_command(input command_type c, output reply_type r);
      bit          found;
      int unsigned id;
      int unsigned best;
      logic [31:0] age, best_age;
      id    = c.tid;
      found = (id >= 1 && id <= pats_pkg::MaxThreads) && tbl_status[id] != pats_pkg::ST_UNUSED;
      r     = '{default: '0};
      best  = 0;
      best_age = '0;
      case (c.op)
         pats_pkg::OP_CREATE: if (next_id <= pats_pkg::MaxThreads) begin
            tbl_status[next_id] = pats_pkg::ST_INIT;
            tbl_prio[next_id]   = limit_prio(c.prio);
            tbl_aff[next_id]    = default_aff;
            tbl_stamp[next_id]  = '0;
            r.ok  = 1'b1;
            r.tid = 6'(next_id);
            next_id++;
         end
         pats_pkg::OP_START: if (found) begin
            mark_ready(id);
            r.ok = 1'b1;
         end
         pats_pkg::OP_YIELD: if (found) begin
            if (tbl_status[id] == pats_pkg::ST_RUNNING) mark_ready(id);
            r.ok = 1'b1;
         end
         pats_pkg::OP_TERMINATE: if (found) begin
            tbl_status[id] = pats_pkg::ST_TERMINATED;
            r.ok = 1'b1;
         end
         pats_pkg::OP_SET_PRIO: if (found) begin
            tbl_prio[id] = limit_prio(c.prio);
            if (tbl_status[id] == pats_pkg::ST_READY) mark_ready(id);
            r.ok = 1'b1;
         end
         pats_pkg::OP_GET_PRIO: if (found) begin
            r.prio = tbl_prio[id];
            r.ok   = 1'b1;
         end
         pats_pkg::OP_SET_AFF: if (found) begin
            tbl_aff[id] = c.mask;
            r.ok = 1'b1;
         end
         pats_pkg::OP_GET_AFF: if (found) begin
            r.aff = tbl_aff[id];
            r.ok  = 1'b1;
         end
         pats_pkg::OP_SCHEDULE: begin
            // lowest level first, oldest stamp within a level, lower id on a tie
            for (int unsigned i = 1; i <= pats_pkg::MaxThreads; i++) begin
               if (tbl_status[i] == pats_pkg::ST_READY && tbl_aff[i][c.cpu]) begin
                  age = stamp_ctr - tbl_stamp[i];
                  if (best == 0 || tbl_prio[i] < tbl_prio[best] ||
                      (tbl_prio[i] == tbl_prio[best] && age > best_age)) begin
                     best     = i;
                     best_age = age;
                  end
               end
            end
            if (best != 0) begin
               tbl_status[best] = pats_pkg::ST_RUNNING;
               r.ok  = 1'b1;
               r.tid = 6'(best);
            end
         end
         default: ;
      endcase
      for (int unsigned i = 1; i <= pats_pkg::MaxThreads; i++) begin
         if (tbl_status[i] == pats_pkg::ST_READY) begin
            r.nready++;
            r.nactive++;
         end else if (tbl_status[i] == pats_pkg::ST_RUNNING) begin
            r.nactive++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
   endtask

   // driver: one command per transfer, random gaps unless calm
   always @(posedge clock) begin
      reply_type r;
      command_type c;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            run_command('{req_op, req_thread_id, req_priority_req, req_cpu,
                          req_affinity_mask}, r);
            expected_replies.insert(expected_replies.size(), r);
         end
         if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
            c = pending_cmds.pop_front();
            start             <= 1'b1;
            req_op            <= c.op;
            req_thread_id     <= c.tid;
            req_priority_req  <= c.prio;
            req_cpu           <= c.cpu;
            req_affinity_mask <= c.mask;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: results come as one-cycle strobes
   always @(posedge clock) begin
      reply_type w;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_thread_id_out), 0);
         end else begin
            w = expected_replies.pop_front();
            if (rsp_ok !== w.ok) report_mismatch("ok", 32'(rsp_ok), 32'(w.ok));
            if (rsp_thread_id_out !== w.tid)
               report_mismatch("thread_id_out", 32'(rsp_thread_id_out), 32'(w.tid));
            if (rsp_prio_level !== w.prio)
               report_mismatch("prio_level", 32'(rsp_prio_level), 32'(w.prio));
            if (rsp_affinity_out !== w.aff)
               report_mismatch("affinity_out", 32'(rsp_affinity_out), 32'(w.aff));
            if (rsp_ready_count !== w.nready)
               report_mismatch("ready_count", 32'(rsp_ready_count), 32'(w.nready));
            if (rsp_active_count !== w.nactive)
               report_mismatch("active_count", 32'(rsp_active_count), 32'(w.nactive));
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("** priority_affinity_thread_scheduler_top: FAILED **");
         $finish;
      end
   end

   task automatic push_cmd(logic [3:0] op, logic [5:0] tid, logic [7:0] prio,
                           logic [3:0] cpu, logic [15:0] mask);
      command_type c;
      c = '{op, tid, prio, cpu, mask};
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_cmds.size() > 0 || expected_replies.size() > 0 || start)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_default_aff(logic [15:0] value);
      wait_idle();
      csr_valid            <= 1'b1;
      csr_default_affinity <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      default_aff = value;
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int n);
      int unsigned sel;
      logic [3:0]  op;
      logic [5:0]  tid;
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(99);
         if      (sel < 3)  op = pats_pkg::OP_CREATE;
         else if (sel < 23) op = pats_pkg::OP_START;
         else if (sel < 35) op = pats_pkg::OP_YIELD;
         else if (sel < 40) op = pats_pkg::OP_TERMINATE;
         else if (sel < 48) op = pats_pkg::OP_SET_PRIO;
         else if (sel < 54) op = pats_pkg::OP_GET_PRIO;
         else if (sel < 62) op = pats_pkg::OP_SET_AFF;
         else if (sel < 68) op = pats_pkg::OP_GET_AFF;
         else if (sel < 97) op = pats_pkg::OP_SCHEDULE;
         else               op = 4'($urandom_range(9, 15));
         tid = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(1, 32));
         push_cmd(op, tid, 8'($urandom_range(255)), 4'($urandom_range(15)),
                  16'($urandom_range(16'hFFFF)));
      end
   endtask

   initial begin
      for (int unsigned i = 1; i <= pats_pkg::MaxThreads; i++) begin
         tbl_status[i] = pats_pkg::ST_UNUSED;
         tbl_prio[i]   = '0;
         tbl_aff[i]    = '0;
         tbl_stamp[i]  = '0;
      end
      next_id     = 1;
      stamp_ctr   = '0;
      default_aff = 16'hFFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: clamping, bad ids, bad ops, idle schedule, requeue cases
      write_default_aff(16'hFFFF);
      push_cmd(pats_pkg::OP_SCHEDULE, 6'd0, 8'd0, 4'd15, 16'h0);
      push_cmd(pats_pkg::OP_CREATE, 6'd0, 8'd255, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_CREATE, 6'd0, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_CREATE, 6'd0, 8'd31, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_GET_PRIO, 6'd1, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_START, 6'd0, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_START, 6'd33, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_GET_AFF, 6'd63, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_YIELD, 6'd20, 8'd0, 4'd0, 16'h0);
      push_cmd(4'd15, 6'd1, 8'd0, 4'd0, 16'h0);
      push_cmd(4'd9, 6'd1, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_START, 6'd2, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_START, 6'd3, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_START, 6'd2, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_YIELD, 6'd3, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_SET_PRIO, 6'd3, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_SET_AFF, 6'd2, 8'd0, 4'd0, 16'h8000);
      push_cmd(pats_pkg::OP_GET_AFF, 6'd2, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_SCHEDULE, 6'd0, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_SCHEDULE, 6'd0, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_SCHEDULE, 6'd0, 8'd0, 4'd15, 16'h0);
      push_cmd(pats_pkg::OP_YIELD, 6'd3, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_TERMINATE, 6'd3, 8'd0, 4'd0, 16'h0);
      push_cmd(pats_pkg::OP_SET_AFF, 6'd1, 8'd0, 4'd0, 16'hFFFF);
      push_cmd(pats_pkg::OP_SCHEDULE, 6'd0, 8'd0, 4'd7, 16'h0);

      write_default_aff(16'h0000);
      random_phase(250);
      write_default_aff(16'hFFFF);
      calm = 1'b1;
      random_phase(250);
      write_default_aff(16'($urandom_range(16'hFFFF)));
      calm = 1'b0;
      random_phase(250);
      write_default_aff(16'h5A5A);
      random_phase(250);
      write_default_aff(16'($urandom_range(16'hFFFF)));
      random_phase(250);
      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_replies.size() == 0) begin
         $display("** priority_affinity_thread_scheduler_top: PASSED **");
      end else begin
         $display("** priority_affinity_thread_scheduler_top: FAILED **");
      end
      $finish;
   end

endmodule
